>>> src/rpa_pkg.sv
package rpa_pkg;

   localparam int NUM_PAGES_DEF  = 32768;
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int COUNT_BITS_DEF = 16;

   localparam int ADDR_W    = 64;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int REF_OUT_W = 16;
   localparam int CSR_IDX_W = 8;

   localparam logic [ADDR_W-1:0] MEMORY_BASE_RST = 64'h0000_0000_8000_0000;
   localparam logic [ADDR_W-1:0] FIRST_FREE_RST  = 64'h0000_0000_8000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC  = 3'd0,
      OP_FREE   = 3'd1,
      OP_REFINC = 3'd2,
      OP_REFGET = 3'd3,
      OP_INIT   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_OOM  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEMORY_BASE = 8'd0,
      CSR_FIRST_FREE  = 8'd1
   } csr_idx_type;

   // address checks of one request
   typedef struct packed {
      logic in_range;
      logic free_ok;
   } addr_chk_type;

endpackage

>>> src/rpa_intf.sv
interface rpa_req_if import rpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] phys_addr;

   modport source (output valid, op, phys_addr, input ready);
   modport sink (input valid, op, phys_addr, output ready);
endinterface

interface rpa_rsp_if import rpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ADDR_W-1:0]    page_addr;
   logic [REF_OUT_W-1:0] ref_count;
   logic                 page_released;

   modport source (output valid, status, page_addr, ref_count, page_released, input ready);
   modport sink (input valid, status, page_addr, ref_count, page_released, output ready);
endinterface

interface rpa_csr_if import rpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/rpa_ram.sv
module rpa_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read data holds until the next read, so a stalled consumer keeps it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rpa_decode.sv
module rpa_decode import rpa_pkg::*; #(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   localparam int IDX_W      = $clog2(NUM_PAGES),
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES),
   localparam int PNUM_W     = ADDR_W - PAGE_SHIFT
) (
   input  logic [ADDR_W-1:0] memory_base,
   input  logic [ADDR_W-1:0] first_free_addr,
   input  logic [ADDR_W-1:0] phys_addr,
   output logic [IDX_W-1:0]  page_idx,
   output addr_chk_type      chk
);

   logic [ADDR_W-1:0] offset;
   logic [PNUM_W-1:0] page_num;
   logic              in_range;

   assign offset   = phys_addr - memory_base;
   assign page_num = offset[ADDR_W-1:PAGE_SHIFT];
   assign page_idx = page_num[IDX_W-1:0];
   assign in_range = (phys_addr >= memory_base) && (page_num < PNUM_W'(NUM_PAGES));

   assign chk.in_range = in_range;
   assign chk.free_ok  = in_range && (phys_addr[PAGE_SHIFT-1:0] == '0)
                         && (phys_addr >= first_free_addr);

endmodule

>>> src/refcounted_page_allocator_top.sv
// channel  | dir | handshake   | payload
// req_bus  | in  | valid/ready | op, phys_addr
// rsp_bus  | out | valid/ready | status, page_addr, ref_count, page_released
// csr_bus  | in  | valid/ready | index, data (always ready)
//
// After reset the count memory is swept to zero, one entry a cycle, with
// req_bus.ready low.
// alloc, free, refinc and refget are accepted (memory read), then S_EXEC writes
// any changed count, pushes a released page on the stack and loads the result.
// init reads each page in S_INIT_RD and writes the ones it takes in S_INIT_WR.
// A result not taken holds the block in its write-back cycle.
module refcounted_page_allocator_top import rpa_pkg::*; #(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   rpa_req_if.sink     req_bus,
   rpa_rsp_if.source   rsp_bus,
   rpa_csr_if.sink     csr_bus
);

   localparam int IDX_W      = $clog2(NUM_PAGES);
   localparam int TOP_W      = $clog2(NUM_PAGES + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_INIT_RD,
      S_INIT_WR
   } state_type;

   function automatic logic [REF_OUT_W-1:0] to_ref(input logic [COUNT_BITS-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[REF_OUT_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        cursor_ff, cursor_in;
   logic [TOP_W-1:0]        top_ff, top_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [ADDR_W-1:0]       first_free_ff, first_free_in;
   logic                    init_full_ff, init_full_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   addr_chk_type            chk_ff, chk_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [REF_OUT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_rel_ff, rsp_rel_in;

   logic [IDX_W-1:0]        dec_idx;
   addr_chk_type            dec_chk;

   logic                    cnt_we, cnt_re;
   logic [IDX_W-1:0]        cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rd, cnt_inc;
   logic                    stk_we, stk_re;
   logic [IDX_W-1:0]        stk_waddr, stk_raddr, stk_wdata, stk_rd;

   logic [TOP_W-1:0]        top_minus1;
   logic                    rsp_free;
   logic                    cursor_last;
   logic                    stack_full;
   logic [ADDR_W:0]         init_sum;
   logic                    init_wrap;
   logic                    init_take;

   rpa_decode #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_decode (
      .memory_base     (base_ff),
      .first_free_addr (first_free_ff),
      .phys_addr       (req_bus.phys_addr),
      .page_idx        (dec_idx),
      .chk             (dec_chk)
   );

   rpa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (COUNT_BITS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd)
   );

   rpa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (IDX_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   assign top_minus1  = top_ff - TOP_W'(1);
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign cursor_last = (cursor_ff == IDX_W'(NUM_PAGES - 1));
   assign stack_full  = (top_ff >= TOP_W'(NUM_PAGES));
   assign cnt_inc     = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);

   // init walk: page address of the cursor, stop once it wraps past 2^64
   assign init_sum  = {1'b0, base_ff} + ((ADDR_W + 1)'(cursor_ff) << PAGE_SHIFT);
   assign init_wrap = init_sum[ADDR_W];
   assign init_take = !init_wrap && (base_ff[PAGE_SHIFT-1:0] == '0)
                      && (init_sum[ADDR_W-1:0] >= first_free_ff);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.page_addr     = rsp_addr_ff;
   assign rsp_bus.ref_count     = rsp_cnt_ff;
   assign rsp_bus.page_released = rsp_rel_ff;

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      top_in        = top_ff;
      base_in       = base_ff;
      first_free_in = first_free_ff;
      init_full_in  = init_full_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      chk_in        = chk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_rel_in    = rsp_rel_ff;

      cnt_we    = 1'b0;
      cnt_waddr = idx_ff;
      cnt_wdata = '0;
      cnt_re    = 1'b0;
      cnt_raddr = dec_idx;
      stk_we    = 1'b0;
      stk_waddr = top_ff[IDX_W-1:0];
      stk_wdata = idx_ff;
      stk_re    = 1'b0;
      stk_raddr = top_minus1[IDX_W-1:0];

      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_MEMORY_BASE) begin
            base_in = csr_bus.data;
         end else if (csr_bus.index == CSR_FIRST_FREE) begin
            first_free_in = csr_bus.data;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = cursor_ff;
            if (cursor_last) begin
               cursor_in = '0;
               state_in  = S_IDLE;
            end else begin
               cursor_in = cursor_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in  = req_bus.op;
               idx_in = dec_idx;
               chk_in = dec_chk;
               cnt_re = 1'b1;
               stk_re = (top_ff != '0);
               if (req_bus.op == OP_INIT) begin
                  cursor_in    = '0;
                  init_full_in = 1'b0;
                  state_in     = S_INIT_RD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = '0;
               rsp_cnt_in    = '0;
               rsp_rel_in    = 1'b0;
               case (op_ff)
                  OP_ALLOC: begin
                     if (top_ff == '0) begin
                        rsp_status_in = ST_OOM;
                     end else begin
                        top_in      = top_minus1;
                        cnt_we      = 1'b1;
                        cnt_waddr   = stk_rd;
                        cnt_wdata   = COUNT_BITS'(1);
                        rsp_cnt_in  = REF_OUT_W'(1);
                        rsp_addr_in = base_ff + (ADDR_W'(stk_rd) << PAGE_SHIFT);
                     end
                  end
                  OP_FREE: begin
                     if (!chk_ff.free_ok) begin
                        rsp_status_in = ST_BAD;
                     end else if (cnt_rd > COUNT_BITS'(1)) begin
                        cnt_we     = 1'b1;
                        cnt_wdata  = cnt_rd - COUNT_BITS'(1);
                        rsp_cnt_in = to_ref(cnt_rd - COUNT_BITS'(1));
                     end else begin
                        cnt_we = 1'b1;
                        if (stack_full) begin
                           rsp_status_in = ST_FULL;
                        end else begin
                           stk_we     = 1'b1;
                           top_in     = top_ff + TOP_W'(1);
                           rsp_rel_in = 1'b1;
                        end
                     end
                  end
                  OP_REFINC: begin
                     if (!chk_ff.in_range) begin
                        rsp_status_in = ST_BAD;
                     end else begin
                        cnt_we     = 1'b1;
                        cnt_wdata  = cnt_inc;
                        rsp_cnt_in = to_ref(cnt_inc);
                     end
                  end
                  OP_REFGET: begin
                     if (!chk_ff.in_range) begin
                        rsp_status_in = ST_BAD;
                     end else begin
                        rsp_cnt_in = to_ref(cnt_rd);
                     end
                  end
                  OP_INIT: begin
                     rsp_status_in = init_full_ff ? ST_FULL : ST_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INIT_RD: begin
            if (init_take) begin
               cnt_re    = 1'b1;
               cnt_raddr = cursor_ff;
               state_in  = S_INIT_WR;
            end else if (init_wrap || cursor_last) begin
               state_in = S_EXEC;
            end else begin
               cursor_in = cursor_ff + IDX_W'(1);
            end
         end
         S_INIT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = cursor_ff;
            if (cnt_rd > COUNT_BITS'(1)) begin
               cnt_wdata = cnt_rd - COUNT_BITS'(1);
            end else if (stack_full) begin
               init_full_in = 1'b1;
            end else begin
               stk_we    = 1'b1;
               stk_wdata = cursor_ff;
               top_in    = top_ff + TOP_W'(1);
            end
            if (cursor_last) begin
               state_in = S_EXEC;
            end else begin
               cursor_in = cursor_ff + IDX_W'(1);
               state_in  = S_INIT_RD;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cursor_ff     <= '0;
         top_ff        <= '0;
         base_ff       <= MEMORY_BASE_RST;
         first_free_ff <= FIRST_FREE_RST;
         init_full_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         top_ff        <= top_in;
         base_ff       <= base_in;
         first_free_ff <= first_free_in;
         init_full_ff  <= init_full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      chk_ff        <= chk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(NUM_PAGES))
      else $error("free stack pointer beyond stack depth");

   a_alloc_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && rsp_free && op_ff == OP_ALLOC && top_ff != '0)
      |=> (top_ff == $past(top_ff) - TOP_W'(1)))
      else $error("alloc did not pop the free stack");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.page_released) |-> (rsp_bus.status == ST_OK))
      else $error("page released with error status");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while another is in progress");

endmodule
